// ===== design/trdt_pkg.sv =====
package trdt_pkg;

  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 480;
  localparam int PIXEL_COUNT   = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int PIX_W         = $clog2(PIXEL_COUNT);

  localparam int BOX_W     = 13;
  localparam int ACC_W     = 64;
  localparam int MUL_B_W   = 26;
  localparam int MUL_STEPS = MUL_B_W;
  localparam int DIV_STEPS = 24;
  localparam int STEP_W    = $clog2(MUL_STEPS);

  localparam logic signed [23:0] DEPTH_MIN = 24'sh800000;

  localparam logic [1:0] OP_DRAW  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Setup multiply sequence: determinant, depth gradients, edge values, depth numerator.
  localparam logic [3:0] MOP_DET_A = 4'd0;
  localparam logic [3:0] MOP_DET_B = 4'd1;
  localparam logic [3:0] MOP_KX_A  = 4'd2;
  localparam logic [3:0] MOP_KX_B  = 4'd3;
  localparam logic [3:0] MOP_KY_A  = 4'd4;
  localparam logic [3:0] MOP_KY_B  = 4'd5;
  localparam logic [3:0] MOP_W0_A  = 4'd6;
  localparam logic [3:0] MOP_W0_B  = 4'd7;
  localparam logic [3:0] MOP_W1_A  = 4'd8;
  localparam logic [3:0] MOP_W1_B  = 4'd9;
  localparam logic [3:0] MOP_N_A   = 4'd10;
  localparam logic [3:0] MOP_N_B   = 4'd11;
  localparam logic [3:0] MOP_N_C   = 4'd12;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_CLR   = 10'b0000000010,
    ST_BOX   = 10'b0000000100,
    ST_MLOAD = 10'b0000001000,
    ST_MITER = 10'b0000010000,
    ST_PIX   = 10'b0000100000,
    ST_DIV   = 10'b0001000000,
    ST_WR    = 10'b0010000000,
    ST_STEP  = 10'b0100000000,
    ST_DONE  = 10'b1000000000
  } state_e;

endpackage

// ===== design/triangle_raster_depth_test_top.sv =====
// A read or unused opcode goes straight to its result; a clear first sweeps every pixel.
// A draw runs its setup multiplies on the shared shift-add multiplier, then steps through each box
// pixel; a covered pixel also runs a restoring division in the shared divider.
// One item at a time; the next transfer is taken once the result sits in the output register.
// Reset clears control state and then sweeps the store of depth and colour, one pixel a
// cycle, before the first item is taken.
module triangle_raster_depth_test_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         opcode_i,
  input  logic signed [15:0] vertex0_x_i,
  input  logic signed [15:0] vertex0_y_i,
  input  logic signed [23:0] vertex0_depth_i,
  input  logic signed [15:0] vertex1_x_i,
  input  logic signed [15:0] vertex1_y_i,
  input  logic signed [23:0] vertex1_depth_i,
  input  logic signed [15:0] vertex2_x_i,
  input  logic signed [15:0] vertex2_y_i,
  input  logic signed [23:0] vertex2_depth_i,
  input  logic [23:0]        fill_colour_i,
  input  logic [18:0]        pixel_index_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [18:0]        pixels_written_o,
  output logic [23:0]        read_colour_o,
  output logic signed [23:0] read_depth_o
);
  import trdt_pkg::*;

  state_e state_q, state_d;

  logic [PIX_W-1:0] clr_cnt_q;
  logic             clr_resp_q;
  logic             out_valid_q;

  logic [1:0]         op_q;
  logic signed [15:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
  logic signed [23:0] az_q, bz_q, cz_q;
  logic [23:0]        colour_q;
  logic               rd_ok_q;

  logic signed [BOX_W-1:0] minx_q, maxx_q, miny_q, maxy_q, x_q, y_q;
  logic [PIX_W-1:0]        row_q, waddr_q;

  logic [3:0]               mop_q;
  logic [ACC_W-1:0]         acc_q, a_q;
  logic [MUL_B_W-1:0]       b_q;
  logic [STEP_W-1:0]        step_q;
  logic signed [ACC_W-1:0]  det_q, kx_q, ky_q;
  logic signed [ACC_W-1:0]  w0_q, w1_q, n_q, w0r_q, w1r_q, nr_q;
  logic [DIV_STEPS-1:0]     q_q;
  logic                     neg_q;
  logic [18:0]              cnt_q;
  logic [47:0]              rdata_q;

  logic [18:0]        res_written_q;
  logic [23:0]        res_colour_q;
  logic signed [23:0] res_depth_q;

  logic [47:0] mem [PIXEL_COUNT];
  logic             mem_we, mem_re;
  logic [PIX_W-1:0] mem_waddr, mem_raddr, pix_idx;
  logic [47:0]      mem_wdata;

  logic in_xfer;
  logic out_load;

  logic signed [16:0] a0, b0, a1, b1, ey0;
  logic signed [24:0] dz0, dz1;
  logic signed [18:0] ex, ey;

  logic signed [15:0] lo_x, hi_x, lo_y, hi_y;
  logic signed [16:0] fl_x, fl_y, cl_x, cl_y;
  logic signed [BOX_W-1:0] minx_c, maxx_c, miny_c, maxy_c;
  logic box_empty;

  logic signed [ACC_W-1:0] op_a;
  logic signed [MUL_B_W-1:0] op_b;
  logic mop_first;

  logic [ACC_W-1:0] add_opnd, add_sum;
  logic             add_cin;
  logic             mul_last, div_last;

  logic signed [ACC_W-1:0] w2, n_abs, det_abs;
  logic covered;
  logic signed [23:0] z;
  logic z_pass;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  assign a0  = 17'(by_q) - 17'(cy_q);
  assign b0  = 17'(cx_q) - 17'(bx_q);
  assign a1  = 17'(cy_q) - 17'(ay_q);
  assign b1  = 17'(ax_q) - 17'(cx_q);
  assign ey0 = 17'(ay_q) - 17'(cy_q);
  assign dz0 = 25'(az_q) - 25'(cz_q);
  assign dz1 = 25'(bz_q) - 25'(cz_q);
  assign ex  = (19'(minx_q) <<< 4) + 19'sd8 - 19'(cx_q);
  assign ey  = (19'(miny_q) <<< 4) + 19'sd8 - 19'(cy_q);

  always_comb begin
    lo_x = (ax_q < bx_q) ? ax_q : bx_q;
    lo_x = (lo_x < cx_q) ? lo_x : cx_q;
    hi_x = (ax_q > bx_q) ? ax_q : bx_q;
    hi_x = (hi_x > cx_q) ? hi_x : cx_q;
    lo_y = (ay_q < by_q) ? ay_q : by_q;
    lo_y = (lo_y < cy_q) ? lo_y : cy_q;
    hi_y = (ay_q > by_q) ? ay_q : by_q;
    hi_y = (hi_y > cy_q) ? hi_y : cy_q;
    fl_x = 17'(lo_x) >>> 4;
    fl_y = 17'(lo_y) >>> 4;
    cl_x = (17'(hi_x) + 17'sd15) >>> 4;
    cl_y = (17'(hi_y) + 17'sd15) >>> 4;
    minx_c = (fl_x < 17'sd0) ? '0 : BOX_W'(fl_x);
    miny_c = (fl_y < 17'sd0) ? '0 : BOX_W'(fl_y);
    maxx_c = (cl_x > 17'(SCREEN_WIDTH - 1)) ? BOX_W'(SCREEN_WIDTH - 1) : BOX_W'(cl_x);
    maxy_c = (cl_y > 17'(SCREEN_HEIGHT - 1)) ? BOX_W'(SCREEN_HEIGHT - 1) : BOX_W'(cl_y);
    box_empty = (minx_c > maxx_c) || (miny_c > maxy_c);
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (mop_q)
      MOP_DET_A: begin op_a = ACC_W'(b1);   op_b = MUL_B_W'(a0); end
      MOP_DET_B: begin op_a = ACC_W'(ey0);  op_b = MUL_B_W'(b0); end
      MOP_KX_A:  begin op_a = ACC_W'(dz0);  op_b = MUL_B_W'(a0); end
      MOP_KX_B:  begin op_a = ACC_W'(dz1);  op_b = MUL_B_W'(a1); end
      MOP_KY_A:  begin op_a = ACC_W'(dz0);  op_b = MUL_B_W'(b0); end
      MOP_KY_B:  begin op_a = ACC_W'(dz1);  op_b = MUL_B_W'(b1); end
      MOP_W0_A:  begin op_a = ACC_W'(ex);   op_b = MUL_B_W'(a0); end
      MOP_W0_B:  begin op_a = ACC_W'(ey);   op_b = MUL_B_W'(b0); end
      MOP_W1_A:  begin op_a = ACC_W'(ex);   op_b = MUL_B_W'(a1); end
      MOP_W1_B:  begin op_a = ACC_W'(ey);   op_b = MUL_B_W'(b1); end
      MOP_N_A:   begin op_a = kx_q;         op_b = MUL_B_W'(ex); end
      MOP_N_B:   begin op_a = ky_q;         op_b = MUL_B_W'(ey); end
      MOP_N_C:   begin op_a = det_q;        op_b = MUL_B_W'(cz_q); end
      default:   begin op_a = '0;           op_b = '0; end
    endcase
    mop_first = (mop_q == MOP_DET_A) || (mop_q == MOP_KX_A) || (mop_q == MOP_KY_A) ||
                (mop_q == MOP_W0_A) || (mop_q == MOP_W1_A) || (mop_q == MOP_N_A);
  end

  // The one adder serves the shift-add multiplier and the restoring divider.
  assign mul_last = (step_q == STEP_W'(MUL_STEPS - 1));
  assign div_last = (step_q == STEP_W'(DIV_STEPS - 1));

  always_comb begin
    if (state_q == ST_DIV) begin
      add_opnd = ~a_q;
      add_cin  = 1'b1;
    end else begin
      add_opnd = b_q[0] ? (mul_last ? ~a_q : a_q) : '0;
      add_cin  = b_q[0] && mul_last;
    end
    add_sum = acc_q + add_opnd + ACC_W'(add_cin);
  end

  assign w2      = det_q - w0_q - w1_q;
  assign n_abs   = n_q[ACC_W-1] ? -n_q : n_q;
  assign det_abs = det_q[ACC_W-1] ? -det_q : det_q;
  assign covered = det_q[ACC_W-1] ?
                   ((w0_q[ACC_W-1] || (w0_q == '0)) && (w1_q[ACC_W-1] || (w1_q == '0)) &&
                    (w2[ACC_W-1] || (w2 == '0))) :
                   (!w0_q[ACC_W-1] && !w1_q[ACC_W-1] && !w2[ACC_W-1]);
  assign z       = neg_q ? (~q_q + 24'd1) : q_q;
  assign z_pass  = z > $signed(rdata_q[47:24]);
  assign pix_idx = row_q + PIX_W'(x_q);

  assign mem_re    = (in_xfer && (opcode_i == OP_READ)) || ((state_q == ST_PIX) && covered);
  assign mem_raddr = (state_q == ST_IDLE) ? PIX_W'(pixel_index_i) : pix_idx;
  assign mem_we    = (state_q == ST_CLR) || ((state_q == ST_WR) && z_pass);
  assign mem_waddr = (state_q == ST_CLR) ? clr_cnt_q : waddr_q;
  assign mem_wdata = (state_q == ST_CLR) ? {DEPTH_MIN, 24'd0} : {z, colour_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          case (opcode_i)
            OP_DRAW:  state_d = ST_BOX;
            OP_CLEAR: state_d = ST_CLR;
            default:  state_d = ST_DONE;
          endcase
        end
      end
      ST_CLR: begin
        if (clr_cnt_q == PIX_W'(PIXEL_COUNT - 1)) begin
          state_d = clr_resp_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_BOX:   state_d = box_empty ? ST_DONE : ST_MLOAD;
      ST_MLOAD: state_d = ST_MITER;
      ST_MITER: begin
        if (mul_last) begin
          if ((mop_q == MOP_DET_B) && (add_sum == '0)) begin
            state_d = ST_DONE;
          end else if (mop_q == MOP_N_C) begin
            state_d = ST_PIX;
          end else begin
            state_d = ST_MLOAD;
          end
        end
      end
      ST_PIX:  state_d = covered ? ST_DIV : ST_STEP;
      ST_DIV:  state_d = div_last ? ST_WR : ST_DIV;
      ST_WR:   state_d = ST_STEP;
      ST_STEP: begin
        if ((x_q == maxx_q) && (y_q == maxy_q)) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_PIX;
        end
      end
      ST_DONE: state_d = out_load ? ST_IDLE : ST_DONE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_cnt_q   <= '0;
      clr_resp_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLR) begin
        clr_cnt_q <= clr_cnt_q + PIX_W'(1);
      end else begin
        clr_cnt_q <= '0;
      end
      if (in_xfer) begin
        clr_resp_q <= (opcode_i == OP_CLEAR);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q     <= opcode_i;
      ax_q     <= vertex0_x_i;
      ay_q     <= vertex0_y_i;
      az_q     <= vertex0_depth_i;
      bx_q     <= vertex1_x_i;
      by_q     <= vertex1_y_i;
      bz_q     <= vertex1_depth_i;
      cx_q     <= vertex2_x_i;
      cy_q     <= vertex2_y_i;
      cz_q     <= vertex2_depth_i;
      colour_q <= fill_colour_i;
      rd_ok_q  <= {13'd0, pixel_index_i} < 32'(PIXEL_COUNT);
      cnt_q    <= '0;
    end
    case (state_q)
      ST_BOX: begin
        minx_q <= minx_c;
        maxx_q <= maxx_c;
        miny_q <= miny_c;
        maxy_q <= maxy_c;
        mop_q  <= MOP_DET_A;
      end
      ST_MLOAD: begin
        a_q    <= op_a;
        b_q    <= op_b;
        step_q <= '0;
        if (mop_first) begin
          acc_q <= '0;
        end
      end
      ST_MITER: begin
        acc_q  <= add_sum;
        a_q    <= a_q << 1;
        b_q    <= b_q >> 1;
        step_q <= step_q + STEP_W'(1);
        if (mul_last) begin
          mop_q <= mop_q + 4'd1;
          case (mop_q)
            MOP_DET_B: det_q <= add_sum;
            MOP_KX_B:  kx_q  <= add_sum;
            MOP_KY_B:  ky_q  <= add_sum;
            MOP_W0_B: begin
              w0_q  <= add_sum;
              w0r_q <= add_sum;
            end
            MOP_W1_B: begin
              w1_q  <= add_sum;
              w1r_q <= add_sum;
            end
            MOP_N_C: begin
              n_q   <= add_sum;
              nr_q  <= add_sum;
              x_q   <= minx_q;
              y_q   <= miny_q;
              row_q <= PIX_W'(miny_q * SCREEN_WIDTH);
            end
            default: ;
          endcase
        end
      end
      ST_PIX: begin
        if (covered) begin
          acc_q   <= n_abs;
          a_q     <= det_abs << (DIV_STEPS - 1);
          step_q  <= '0;
          q_q     <= '0;
          neg_q   <= n_q[ACC_W-1] ^ det_q[ACC_W-1];
          waddr_q <= pix_idx;
        end
      end
      ST_DIV: begin
        if (!add_sum[ACC_W-1]) begin
          acc_q <= add_sum;
        end
        q_q    <= {q_q[DIV_STEPS-2:0], !add_sum[ACC_W-1]};
        a_q    <= a_q >> 1;
        step_q <= step_q + STEP_W'(1);
      end
      ST_WR: begin
        if (z_pass) begin
          cnt_q <= cnt_q + 19'd1;
        end
      end
      ST_STEP: begin
        if (x_q == maxx_q) begin
          x_q   <= minx_q;
          y_q   <= y_q + BOX_W'(1);
          row_q <= row_q + PIX_W'(SCREEN_WIDTH);
          w0r_q <= w0r_q + (ACC_W'(b0) <<< 4);
          w1r_q <= w1r_q + (ACC_W'(b1) <<< 4);
          nr_q  <= nr_q + (ky_q <<< 4);
          w0_q  <= w0r_q + (ACC_W'(b0) <<< 4);
          w1_q  <= w1r_q + (ACC_W'(b1) <<< 4);
          n_q   <= nr_q + (ky_q <<< 4);
        end else begin
          x_q  <= x_q + BOX_W'(1);
          w0_q <= w0_q + (ACC_W'(a0) <<< 4);
          w1_q <= w1_q + (ACC_W'(a1) <<< 4);
          n_q  <= n_q + (kx_q <<< 4);
        end
      end
      default: ;
    endcase
    if (out_load) begin
      res_written_q <= (op_q == OP_DRAW) ? cnt_q : '0;
      res_colour_q  <= ((op_q == OP_READ) && rd_ok_q) ? rdata_q[23:0] : '0;
      res_depth_q   <= ((op_q == OP_READ) && rd_ok_q) ? $signed(rdata_q[47:24]) : '0;
    end
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign pixels_written_o = res_written_q;
  assign read_colour_o    = res_colour_q;
  assign read_depth_o     = res_depth_q;

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state register is not one-hot");

  a_write_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR) |-> ($past(state_q) == ST_DIV))
    else $error("depth compare entered without a division");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mem_we) else $error("store written while idle");

  a_pix_nonzero_det: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PIX) |-> (det_q != '0)) else $error("degenerate triangle rasterized");
`endif

endmodule

// ===== sim/triangle_raster_depth_test_top_tb.sv =====
module triangle_raster_depth_test_top_tb;
  import trdt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam longint CYCLE_LIMIT = 30_000_000;

  typedef struct {
    logic [1:0]         opcode;
    logic signed [15:0] v0x, v0y, v1x, v1y, v2x, v2y;
    logic signed [23:0] v0z, v1z, v2z;
    logic [23:0]        colour;
    logic [18:0]        pixel_index;
  } raster_cmd_t;

  typedef struct {
    logic [18:0]        pixels_written;
    logic [23:0]        read_colour;
    logic signed [23:0] read_depth;
  } raster_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] opcode_i = OP_UNUSED;
  logic signed [15:0] vertex0_x_i = '0, vertex0_y_i = '0;
  logic signed [15:0] vertex1_x_i = '0, vertex1_y_i = '0;
  logic signed [15:0] vertex2_x_i = '0, vertex2_y_i = '0;
  logic signed [23:0] vertex0_depth_i = '0, vertex1_depth_i = '0, vertex2_depth_i = '0;
  logic [23:0] fill_colour_i = '0;
  logic [18:0] pixel_index_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [18:0] pixels_written_o;
  logic [23:0] read_colour_o;
  logic signed [23:0] read_depth_o;

  triangle_raster_depth_test_top u_top (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  raster_cmd_t    pending_cmds[$];
  raster_result_t expected_results[$];
  logic signed [23:0] depth_mem[PIXEL_COUNT];
  logic [23:0]        colour_mem[PIXEL_COUNT];
  int recent_spots[$];
  int error_count = 0;
  int n_draw = 0, n_read = 0, n_clear = 0, n_other = 0;
  longint total_written = 0;
  longint cycle_count = 0;
  logic cmd_taken = 1'b0;

  function automatic void clear_mems();
    for (int i = 0; i < PIXEL_COUNT; i++) begin
      depth_mem[i] = DEPTH_MIN;
      colour_mem[i] = '0;
    end
  endfunction

  function automatic longint min3(longint a, longint b, longint c);
    longint m;
    m = a < b ? a : b;
    return m < c ? m : c;
  endfunction

  function automatic longint max3(longint a, longint b, longint c);
    longint m;
    m = a > b ? a : b;
    return m > c ? m : c;
  endfunction

  function automatic raster_result_t rasterize(raster_cmd_t c);
    raster_result_t r;
    longint ax, ay, az, bx, by, bz, cx, cy, cz;
    longint det, minx, maxx, miny, maxy, px, py, w0, w1, w2, z, idx, count;
    bit covered;
    r = '{default: '0};
    ax = longint'(c.v0x); ay = longint'(c.v0y); az = longint'(c.v0z);
    bx = longint'(c.v1x); by = longint'(c.v1y); bz = longint'(c.v1z);
    cx = longint'(c.v2x); cy = longint'(c.v2y); cz = longint'(c.v2z);
    count = 0;
    det = (by - cy) * (ax - cx) + (cx - bx) * (ay - cy);
    if (det != 0) begin
      minx = min3(ax, bx, cx) >>> 4;
      maxx = (max3(ax, bx, cx) + 15) >>> 4;
      miny = min3(ay, by, cy) >>> 4;
      maxy = (max3(ay, by, cy) + 15) >>> 4;
      if (minx < 0) minx = 0;
      if (miny < 0) miny = 0;
      if (maxx > SCREEN_WIDTH - 1) maxx = SCREEN_WIDTH - 1;
      if (maxy > SCREEN_HEIGHT - 1) maxy = SCREEN_HEIGHT - 1;
      for (longint y = miny; y <= maxy; y++) begin
        py = y * 16 + 8;
        for (longint x = minx; x <= maxx; x++) begin
          px = x * 16 + 8;
          w0 = (by - cy) * (px - cx) + (cx - bx) * (py - cy);
          w1 = (cy - ay) * (px - cx) + (ax - cx) * (py - cy);
          w2 = det - w0 - w1;
          if (det > 0) covered = (w0 >= 0) && (w1 >= 0) && (w2 >= 0);
          else covered = (w0 <= 0) && (w1 <= 0) && (w2 <= 0);
          if (covered) begin
            z = (w0 * az + w1 * bz + w2 * cz) / det;
            idx = y * SCREEN_WIDTH + x;
            if (z > longint'(depth_mem[idx])) begin
              depth_mem[idx] = z[23:0];
              colour_mem[idx] = c.colour;
              count++;
            end
          end
        end
      end
    end
    r.pixels_written = count[18:0];
    return r;
  endfunction

  function automatic raster_result_t predict_result(raster_cmd_t c);
    raster_result_t r;
    r = '{default: '0};
    case (c.opcode)
      OP_DRAW: begin
        r = rasterize(c);
        n_draw++;
        total_written += longint'(r.pixels_written);
      end
      OP_CLEAR: begin
        clear_mems();
        n_clear++;
      end
      OP_READ: begin
        n_read++;
        if (c.pixel_index < PIXEL_COUNT) begin
          r.read_colour = colour_mem[c.pixel_index];
          r.read_depth = depth_mem[c.pixel_index];
        end
      end
      default: n_other++;
    endcase
    return r;
  endfunction

  function automatic raster_cmd_t noise_cmd(logic [1:0] op);
    raster_cmd_t c;
    c.opcode = op;
    c.v0x = 16'($urandom); c.v0y = 16'($urandom); c.v0z = 24'($urandom);
    c.v1x = 16'($urandom); c.v1y = 16'($urandom); c.v1z = 24'($urandom);
    c.v2x = 16'($urandom); c.v2y = 16'($urandom); c.v2z = 24'($urandom);
    c.colour = 24'($urandom);
    c.pixel_index = 19'($urandom);
    return c;
  endfunction

  task automatic push_tri(int x0, int y0, int z0, int x1, int y1, int z1,
                          int x2, int y2, int z2, logic [23:0] colour);
    raster_cmd_t c;
    c = noise_cmd(OP_DRAW);
    c.v0x = 16'(x0); c.v0y = 16'(y0); c.v0z = 24'(z0);
    c.v1x = 16'(x1); c.v1y = 16'(y1); c.v1z = 24'(z1);
    c.v2x = 16'(x2); c.v2y = 16'(y2); c.v2z = 24'(z2);
    c.colour = colour;
    pending_cmds = {pending_cmds, c};
  endtask

  task automatic push_read(int idx);
    raster_cmd_t c;
    c = noise_cmd(OP_READ);
    c.pixel_index = 19'(idx);
    pending_cmds = {pending_cmds, c};
  endtask

  function automatic int rand_depth();
    if ($urandom_range(0, 1)) return $urandom_range(0, 24'hFFFFFF) - 8388608;
    return $urandom_range(0, 4000) - 2000;
  endfunction

  task automatic push_random_draw();
    int bx, by, spread, xs[3], ys[3];
    if ($urandom_range(0, 9) < 7) begin
      bx = $urandom_range(0, 64 * 16);
      by = $urandom_range(0, 48 * 16);
    end else begin
      bx = $urandom_range(0, 10239);
      by = $urandom_range(0, 7679);
    end
    spread = ($urandom_range(0, 9) == 0) ? 256 : 64;
    for (int i = 0; i < 3; i++) begin
      xs[i] = bx + $urandom_range(0, 2 * spread) - spread;
      ys[i] = by + $urandom_range(0, 2 * spread) - spread;
    end
    if ($urandom_range(0, 19) == 0) begin
      xs[2] = 2 * xs[1] - xs[0];
      ys[2] = 2 * ys[1] - ys[0];
    end
    if (xs[0] >= 0 && ys[0] >= 0 && xs[0] < 10240 && ys[0] < 7680)
      recent_spots = {recent_spots, (ys[0] >>> 4) * SCREEN_WIDTH + (xs[0] >>> 4)};
    if (recent_spots.size() > 32) void'(recent_spots.pop_front());
    push_tri(xs[0], ys[0], rand_depth(), xs[1], ys[1], rand_depth(),
             xs[2], ys[2], rand_depth(), 24'($urandom));
  endtask

  initial begin
    int bursts_left, gap_left, clears_left, sel;
    clear_mems();

    push_read(0);
    push_tri(0, 0, 1000, 64, 0, 2000, 0, 64, 3000, 24'hFFFFFF);
    push_tri(0, 0, 500, 64, 0, 500, 0, 64, 500, 24'h123456);
    push_tri(0, 0, 1000, 64, 0, 2000, 0, 64, 3000, 24'h000000);
    push_tri(200, 200, -8388608, 264, 200, -8388608, 200, 264, -8388608, 24'hABCDEF);
    push_tri(16, 16, 8388607, 48, 16, 8388607, 16, 48, 8388607, 24'h0000FF);
    push_tri(0, 0, 5, 32, 32, 5, 64, 64, 5, 24'hFF0000);
    push_tri(32767, 100, 9, 32767, 200, 9, 32767, 300, 9, 24'h00FF00);
    push_tri(-32768, -32768, 9, -32768, -32000, 9, -32000, -32768, 9, 24'h00FF00);
    push_tri(-32768, 0, 77, 40, 8, -77, 40, 24, 4000, 24'h5A5A5A);
    push_tri(0, -32768, 77, 8, 40, 8388607, 24, 40, -8388608, 24'hA5A5A5);
    push_tri(400, 400, 300, 400, 464, 100, 464, 400, 200, 24'h777777);
    push_tri(10200, 7650, 4000, 10400, 7650, 4000, 10200, 7800, 4000, 24'hC0FFEE);
    push_read(1);
    push_read(2 * SCREEN_WIDTH + 2);
    push_read(PIXEL_COUNT - 1);
    push_read(PIXEL_COUNT);
    push_read(19'h7FFFF);
    pending_cmds = {pending_cmds, noise_cmd(OP_UNUSED)};
    pending_cmds = {pending_cmds, noise_cmd(OP_CLEAR)};
    push_read(1);
    push_read(PIXEL_COUNT - 1);

    clears_left = 2;
    for (int i = 0; i < 850; i++) begin
      sel = $urandom_range(0, 999);
      if (sel < 600) push_random_draw();
      else if (sel < 940) begin
        if (recent_spots.size() > 0 && $urandom_range(0, 3) != 0)
          push_read(recent_spots[$urandom_range(0, recent_spots.size() - 1)]);
        else
          push_read($urandom);
      end else if (sel < 943 && clears_left > 0) begin
        pending_cmds = {pending_cmds, noise_cmd(OP_CLEAR)};
        clears_left--;
      end else pending_cmds = {pending_cmds, noise_cmd(OP_UNUSED)};
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_cmds.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    while (in_valid_i) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("Checked %0d draws (%0d pixels written), %0d reads, %0d clears, %0d unused ops.",
             n_draw, total_written, n_read, n_clear, n_other);
    $display("Sender ran in random bursts; the receiver stalled in random patterns.");
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  int burst_cnt = 0, gap_cnt = 0;
  always @(negedge clk_i) begin
    raster_cmd_t c;
    if (rst_ni && (!in_valid_i || cmd_taken)) begin
      if (gap_cnt > 0) begin
        gap_cnt <= gap_cnt - 1;
        in_valid_i <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        c = pending_cmds.pop_front();
        in_valid_i <= 1'b1;
        opcode_i <= c.opcode;
        vertex0_x_i <= c.v0x; vertex0_y_i <= c.v0y; vertex0_depth_i <= c.v0z;
        vertex1_x_i <= c.v1x; vertex1_y_i <= c.v1y; vertex1_depth_i <= c.v1z;
        vertex2_x_i <= c.v2x; vertex2_y_i <= c.v2y; vertex2_depth_i <= c.v2z;
        fill_colour_i <= c.colour;
        pixel_index_i <= c.pixel_index;
        if (burst_cnt <= 1) begin
          burst_cnt <= $urandom_range(1, 12);
          gap_cnt <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end else begin
          burst_cnt <= burst_cnt - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  int stall_mode = 0, stall_phase = 0;
  always @(negedge clk_i) begin
    if (stall_phase == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_phase <= $urandom_range(20, 400);
    end else begin
      stall_phase <= stall_phase - 1;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 1) == 1);
      2: out_stall_i <= (stall_phase % 8) < 5;
      default: out_stall_i <= ($urandom_range(0, 9) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    raster_cmd_t c;
    raster_result_t exp_r;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit.");
      $display("FAILURE");
      $finish;
    end else begin
      cmd_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        c.opcode = opcode_i;
        c.v0x = vertex0_x_i; c.v0y = vertex0_y_i; c.v0z = vertex0_depth_i;
        c.v1x = vertex1_x_i; c.v1y = vertex1_y_i; c.v1z = vertex1_depth_i;
        c.v2x = vertex2_x_i; c.v2y = vertex2_y_i; c.v2z = vertex2_depth_i;
        c.colour = fill_colour_i;
        c.pixel_index = pixel_index_i;
        expected_results = {expected_results, predict_result(c)};
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("Result transfer with no result expected.");
          error_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (pixels_written_o !== exp_r.pixels_written) begin
            $error("pixels_written: expected %0d, got %0d",
                   exp_r.pixels_written, pixels_written_o);
            error_count++;
          end
          if (read_colour_o !== exp_r.read_colour) begin
            $error("read_colour: expected %h, got %h", exp_r.read_colour, read_colour_o);
            error_count++;
          end
          if (read_depth_o !== exp_r.read_depth) begin
            $error("read_depth: expected %0d, got %0d", exp_r.read_depth, read_depth_o);
            error_count++;
          end
        end
      end
    end
  end

endmodule

// ===== sim.f =====
design/trdt_pkg.sv
design/triangle_raster_depth_test_top.sv
sim/triangle_raster_depth_test_top_tb.sv
